>>> rtl/core/fds_pkg.sv
`timescale 1ns / 1ps

package fds_pkg;

  // Window geometry and fixed-point format
  localparam int WIN_DEPTH = 6;
  localparam int FRAC_BITS = 16;
  localparam int COEF_WIDTH = 32;

  // Reset value of the reciprocal register: 1.0 in unsigned Q16.16
  localparam logic [COEF_WIDTH-1:0] INV_RESET = 32'h0001_0000;

  // Kind of result burst that one accepted sample launches
  localparam logic [1:0] KIND_SHORT  = 2'd0;  // grid ended before six samples
  localparam logic [1:0] KIND_START  = 2'd1;  // sixth sample: forward stencils and more
  localparam logic [1:0] KIND_STEADY = 2'd2;  // central stencil, plus backward ones on last

  typedef struct packed {
    logic [1:0] kind;
    logic       last;
  } job_t;

endpackage

>>> rtl/core/fourth_derivative_stencil_unit.sv
`timescale 1ns / 1ps

// A sample is registered in stages 0 to 4 and then in the emitter, which offers
// its first result. Throughput: one sample per cycle while the output keeps up;
// the sixth sample of a grid emits 4 results (6 if also the last), a closing
// sample 3, one per cycle on the output port while m_tready is high, which holds
// off the input once the 5-stage pipeline is full. Reset: synchronous, active
// high; empties the pipeline and sample count, sets the reciprocal register to 1.0.
module fourth_derivative_stencil_unit #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration: inv_step_pow4
  input  logic                               cfg_wr_en,
  input  logic [fds_pkg::COEF_WIDTH-1:0]     cfg_wr_data,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [8*((SAMPLE_WIDTH+7)/8)-1:0]  s_tdata,   // [SAMPLE_WIDTH-1:0] sample
  input  logic                               s_tlast,   // last_sample
  // output stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [8*((SAMPLE_WIDTH+7)/8)-1:0]  m_tdata,   // [SAMPLE_WIDTH-1:0] derivative
  output logic [1:0]                         m_tuser,   // [0] saturated, [1] too_short
  output logic                               m_tlast    // last_result
);

  localparam int W       = SAMPLE_WIDTH;
  localparam int SUM_W   = W + 4;        // exact stencil sum, signed
  localparam int MAG_W   = W + 3;        // magnitude of the sum
  localparam int HALF_W  = 32;
  localparam int PROD_W  = MAG_W + fds_pkg::COEF_WIDTH;
  localparam int Q_W     = W + 1;
  localparam int CNT_W   = $clog2(fds_pkg::WIN_DEPTH + 1);
  localparam int IDX_W   = 3;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(fds_pkg::WIN_DEPTH);
  localparam logic [CNT_W-1:0] CNT_SIXTH = CNT_W'(fds_pkg::WIN_DEPTH - 1);

  // configuration register
  logic [fds_pkg::COEF_WIDTH-1:0] inv_step_pow4;

  // stage 0: sample window and job descriptor
  logic signed [W-1:0] win [fds_pkg::WIN_DEPTH];
  logic [CNT_W-1:0]    samples_seen;
  logic                v0;
  fds_pkg::job_t       job0;

  // stage 1: sign and magnitude of the two sums (lane 0: w[0..4], lane 1: w[1..5])
  logic             v1;
  fds_pkg::job_t    job1;
  logic             neg1 [2];
  logic [MAG_W-1:0] mag1 [2];

  // stage 2: partial products
  logic             v2;
  fds_pkg::job_t    job2;
  logic             neg2 [2];
  logic [63:0]      plo2 [2];
  logic [63:0]      phi2 [2];

  // stage 3: full product
  logic              v3;
  fds_pkg::job_t     job3;
  logic              neg3 [2];
  logic [PROD_W-1:0] prod3 [2];

  // stage 4: rounded and saturated results
  logic          v4;
  fds_pkg::job_t job4;
  logic [W-1:0]  r4_val [2];
  logic          r4_sat [2];

  // emitter: holds one job and steps through its results
  logic             e_valid;
  fds_pkg::job_t    e_job;
  logic [W-1:0]     e_val [2];
  logic             e_sat [2];
  logic [IDX_W-1:0] e_idx;
  logic [IDX_W-1:0] e_cnt;

  logic rdy_e, rdy1, rdy2, rdy3, rdy4;
  logic s_fire, e_final;

  // stage ready chain
  always_comb begin
    e_final  = (e_idx == e_cnt - IDX_W'(1));
    rdy_e    = !e_valid || (e_final && m_tready);
    rdy4     = !v4 || rdy_e;
    rdy3     = !v3 || rdy4;
    rdy2     = !v2 || rdy3;
    rdy1     = !v1 || rdy2;
    s_tready = !v0 || rdy1;
    s_fire   = s_tvalid && s_tready;
  end

  // configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_step_pow4 <= fds_pkg::INV_RESET;
    end else if (cfg_wr_en) begin
      inv_step_pow4 <= cfg_wr_data;
    end
  end

  // job classification of the incoming sample
  logic             has_job;
  fds_pkg::job_t    job_next;
  logic [CNT_W-1:0] samples_seen_next;

  always_comb begin
    has_job           = 1'b1;
    job_next.last     = s_tlast;
    job_next.kind     = fds_pkg::KIND_STEADY;
    samples_seen_next = s_tlast ? '0 : CNT_FULL;
    priority if (samples_seen < CNT_SIXTH) begin
      job_next.kind = fds_pkg::KIND_SHORT;
      has_job       = s_tlast;
      if (!s_tlast) begin
        samples_seen_next = samples_seen + CNT_W'(1);
      end
    end else if (samples_seen == CNT_SIXTH) begin
      job_next.kind = fds_pkg::KIND_START;
    end else begin
      job_next.kind = fds_pkg::KIND_STEADY;
    end
  end

  // stage 0 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v0           <= 1'b0;
      samples_seen <= '0;
    end else if (s_fire) begin
      v0           <= has_job;
      samples_seen <= samples_seen_next;
    end else if (rdy1) begin
      v0 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      for (int i = 0; i < fds_pkg::WIN_DEPTH - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[fds_pkg::WIN_DEPTH-1] <= s_tdata[W-1:0];
      job0 <= job_next;
    end
  end

  // stage 1 logic: 1,-4,6,-4,1 stencil and absolute value
  logic signed [SUM_W-1:0] sum1 [2];
  logic signed [SUM_W-1:0] a0 [2];
  logic signed [SUM_W-1:0] a1 [2];
  logic signed [SUM_W-1:0] a2 [2];
  logic signed [SUM_W-1:0] a3 [2];
  logic signed [SUM_W-1:0] a4 [2];

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      a0[b]   = SUM_W'(win[b]);
      a1[b]   = SUM_W'(win[b+1]);
      a2[b]   = SUM_W'(win[b+2]);
      a3[b]   = SUM_W'(win[b+3]);
      a4[b]   = SUM_W'(win[b+4]);
      sum1[b] = a0[b] + a4[b] + (a2[b] <<< 2) + (a2[b] <<< 1)
                - ((a1[b] + a3[b]) <<< 2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      job1 <= job0;
      for (int b = 0; b < 2; b++) begin
        neg1[b] <= sum1[b][SUM_W-1];
        mag1[b] <= sum1[b][SUM_W-1] ? MAG_W'(-sum1[b]) : MAG_W'(sum1[b]);
      end
    end
  end

  // stage 2: two 32x32 partial products per lane
  logic [63:0] mag_ext [2];

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      mag_ext[b] = 64'(mag1[b]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      job2 <= job1;
      for (int b = 0; b < 2; b++) begin
        neg2[b] <= neg1[b];
        plo2[b] <= 64'(mag_ext[b][HALF_W-1:0]) * 64'(inv_step_pow4);
        phi2[b] <= 64'(mag_ext[b][63:HALF_W]) * 64'(inv_step_pow4);
      end
    end
  end

  // stage 3: combine partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      job3 <= job2;
      for (int b = 0; b < 2; b++) begin
        neg3[b]  <= neg2[b];
        prod3[b] <= (PROD_W'(phi2[b]) << HALF_W) + PROD_W'(plo2[b]);
      end
    end
  end

  // stage 4: round half away from zero, saturate, restore sign
  logic         big4 [2];
  logic [Q_W-1:0] q4 [2];
  logic [Q_W-1:0] lim4 [2];
  logic [Q_W-1:0] qs4 [2];
  logic         sat4 [2];
  logic [W-1:0] val4 [2];

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      big4[b] = |prod3[b][PROD_W-1:W+fds_pkg::FRAC_BITS];
      q4[b]   = Q_W'(prod3[b][W+fds_pkg::FRAC_BITS-1:fds_pkg::FRAC_BITS])
                + Q_W'(prod3[b][fds_pkg::FRAC_BITS-1]);
      lim4[b] = neg3[b] ? (Q_W'(1) << (W - 1)) : ((Q_W'(1) << (W - 1)) - Q_W'(1));
      sat4[b] = big4[b] || (q4[b] > lim4[b]);
      qs4[b]  = sat4[b] ? lim4[b] : q4[b];
      val4[b] = neg3[b] ? W'(-qs4[b]) : W'(qs4[b]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      job4 <= job3;
      for (int b = 0; b < 2; b++) begin
        r4_val[b] <= val4[b];
        r4_sat[b] <= sat4[b];
      end
    end
  end

  // emitter: result count per job
  logic [IDX_W-1:0] cnt4;

  always_comb begin
    unique case (job4.kind)
      fds_pkg::KIND_SHORT:  cnt4 = IDX_W'(1);
      fds_pkg::KIND_START:  cnt4 = job4.last ? IDX_W'(6) : IDX_W'(4);
      fds_pkg::KIND_STEADY: cnt4 = job4.last ? IDX_W'(3) : IDX_W'(1);
      default:              cnt4 = IDX_W'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      e_idx   <= '0;
    end else if (rdy_e && v4) begin
      e_valid <= 1'b1;
      e_idx   <= '0;
    end else if (e_valid && m_tready) begin
      if (e_final) begin
        e_valid <= 1'b0;
      end else begin
        e_idx <= e_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_e && v4) begin
      e_job <= job4;
      e_cnt <= cnt4;
      for (int b = 0; b < 2; b++) begin
        e_val[b] <= r4_val[b];
        e_sat[b] <= r4_sat[b];
      end
    end
  end

  // result selection: the start burst alternates lanes 0 and 1; a steady burst takes lane 1, then lanes 0 and 1
  logic e_lane;

  always_comb begin
    unique case (e_job.kind)
      fds_pkg::KIND_START:  e_lane = e_idx[0];
      fds_pkg::KIND_STEADY: e_lane = (e_idx != IDX_W'(1));
      default:              e_lane = 1'b0;
    endcase
  end

  always_comb begin
    m_tvalid = e_valid;
    m_tdata  = '0;
    m_tuser  = '0;
    if (e_job.kind == fds_pkg::KIND_SHORT) begin
      m_tuser[1] = 1'b1;
    end else begin
      m_tdata[W-1:0] = e_val[e_lane];
      m_tuser[0]     = e_sat[e_lane];
    end
    m_tlast = e_job.last && e_final;
  end

endmodule

>>> rtl/core/fds_checker.sv
`timescale 1ns / 1ps

module fds_checker #(
  parameter int SAMPLE_WIDTH = 32
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [8*((SAMPLE_WIDTH+7)/8)-1:0] m_tdata,
  input logic [1:0]                        m_tuser,
  input logic                              m_tlast
);

  localparam int W = SAMPLE_WIDTH;
  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

  // output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered right after reset");

  // a stalled result keeps its contents
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // short-grid result is a lone zero that closes the grid
  a_short_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata == '0 && !m_tuser[0] && m_tlast)
    else $error("malformed short-grid result");

  // a clipped result sits at one of the range limits
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[W-1:0] == MAX_POS || m_tdata[W-1:0] == MIN_NEG)
    else $error("saturated result not at a limit");

endmodule

bind fourth_derivative_stencil_unit fds_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_fds_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int SW           = 32;
  localparam int DW           = 8 * ((SW + 7) / 8);
  localparam int MAX_GAP      = 12;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE       = 12;
  localparam int PHASE_ITEMS  = 38;
  localparam int NUM_PHASES   = 7;
  localparam int LIMIT_CYCLES = 400000;

  localparam logic [31:0] SAMPLE_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAMPLE_MIN = 32'h8000_0000;

  // sample value styles
  localparam int STYLE_FULL    = 0;
  localparam int STYLE_SMALL   = 1;
  localparam int STYLE_EXTREME = 2;
  localparam int STYLE_MIXED   = 3;

  typedef struct {
    logic [31:0] derivative;
    logic        saturated;
    logic        too_short;
    logic        last_result;
  } stencil_result_t;

  // Expected fourth derivatives, predicted from the accepted samples
  class stencil_scoreboard;
    logic [fds_pkg::COEF_WIDTH-1:0] inv_step;
    logic signed [31:0]             window [6];
    int unsigned                    seen;
    stencil_result_t                expected_q [$];
    int                             errors;
    int                             samples_noted;
    int                             results_checked;
    int                             saturated_count;
    int                             short_count;

    function new();
      inv_step = fds_pkg::INV_RESET;
      foreach (window[i]) window[i] = '0;
      seen = 0;
      errors = 0;
      samples_noted = 0;
      results_checked = 0;
      saturated_count = 0;
      short_count = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // weighted 1,-4,6,-4,1 sum over window[base..base+4], scaled and rounded
    function stencil_result_t stencil_at(int base, logic final_flag);
      stencil_result_t r;
      logic signed [39:0] s;
      logic [39:0] mag;
      logic [71:0] prod;
      logic [71:0] q;
      logic [71:0] lim;
      logic neg;
      s = window[base] - 4 * window[base+1] + 6 * window[base+2]
          - 4 * window[base+3] + window[base+4];
      neg = s < 0;
      mag = neg ? -s : s;
      prod = mag * inv_step;
      q = (prod >> fds_pkg::FRAC_BITS) + prod[fds_pkg::FRAC_BITS-1];
      lim = neg ? 72'h8000_0000 : 72'h7FFF_FFFF;
      r.saturated = 1'b0;
      if (q > lim) begin
        q = lim;
        r.saturated = 1'b1;
      end
      r.derivative = neg ? -q[31:0] : q[31:0];
      r.too_short = 1'b0;
      r.last_result = final_flag;
      return r;
    endfunction

    // one accepted input transaction
    function void note_sample(logic [31:0] value, logic last);
      stencil_result_t r;
      int unsigned prior;
      prior = seen;
      samples_noted++;
      for (int i = 0; i < 5; i++) window[i] = window[i+1];
      window[5] = value;
      if (seen < 6) seen++;

      if (prior + 1 < 6) begin
        // grid ended too early: one flagged result
        if (last) begin
          r.derivative = '0;
          r.saturated = 1'b0;
          r.too_short = 1'b1;
          r.last_result = 1'b1;
          expected_q.push_back(r);
          seen = 0;
        end
        return;
      end

      if (prior + 1 == 6) begin
        // forward stencils for points 0,1 then central for points 2,3
        expected_q.push_back(stencil_at(0, 1'b0));
        expected_q.push_back(stencil_at(1, 1'b0));
        expected_q.push_back(stencil_at(0, 1'b0));
        expected_q.push_back(stencil_at(1, 1'b0));
      end else begin
        expected_q.push_back(stencil_at(1, 1'b0));
      end
      // closing sample adds the two backward stencils
      if (last) begin
        expected_q.push_back(stencil_at(0, 1'b0));
        expected_q.push_back(stencil_at(1, 1'b1));
        seen = 0;
      end
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    endfunction

    // one accepted output transaction
    function void check_result(logic [31:0] data, logic [1:0] user, logic lst);
      stencil_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, got derivative %h user %b last %b",
                 $time, data, user, lst);
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      if (want.saturated) saturated_count++;
      if (want.too_short) short_count++;
      if (data !== want.derivative)  report("derivative", want.derivative, data);
      if (user[0] !== want.saturated) report("saturated", want.saturated, user[0]);
      if (user[1] !== want.too_short) report("too_short", want.too_short, user[1]);
      if (lst !== want.last_result)  report("last_result", want.last_result, lst);
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_wr_en;
  logic [fds_pkg::COEF_WIDTH-1:0] cfg_wr_data;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [DW-1:0]                  s_tdata;   // [31:0] sample
  logic                           s_tlast;   // last_sample
  logic                           m_tvalid;
  logic                           m_tready;
  logic [DW-1:0]                  m_tdata;   // [31:0] derivative
  logic [1:0]                     m_tuser;   // [0] saturated, [1] too_short
  logic                           m_tlast;   // last_result

  stencil_scoreboard board;
  bit                no_idle;
  bit                sender_rush;
  bit                hold_request;
  int                grids_sent;
  int                settings_used;
  int unsigned       cycle_count = 0;
  logic [31:0]       pattern [$];

  always #2 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  fourth_derivative_stencil_unit #(.SAMPLE_WIDTH(SW)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  function automatic logic [31:0] pick_sample(int style);
    int v;
    int sel;
    sel = (style == STYLE_MIXED) ? $urandom_range(0, 2) : style;
    case (sel)
      STYLE_SMALL: begin
        v = int'($urandom_range(0, 8191)) - 4096;
        return v;
      end
      STYLE_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_grid_len();
    if ($urandom_range(0, 7) == 0) return $urandom_range(1, 5);
    if ($urandom_range(0, 9) == 0) return $urandom_range(25, 40);
    return $urandom_range(6, 14);
  endfunction

  // one input transaction, after a random gap unless no_idle or sender_rush is set
  task automatic send_sample(input logic [31:0] value, input logic last);
    int gap;
    gap = (no_idle || sender_rush) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_sample(value, last);
  endtask

  task automatic send_pattern();
    foreach (pattern[i]) send_sample(pattern[i], i == pattern.size() - 1);
    grids_sent++;
  endtask

  task automatic send_random_grid(input int len, input int style);
    for (int i = 0; i < len; i++) send_sample(pick_sample(style), i == len - 1);
    grids_sent++;
  endtask

  // stop offering, wait for every expected result, then let the pipeline settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_inv(input logic [31:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.inv_step = value;
    settings_used++;
  endtask

  function automatic logic [31:0] phase_inv(int p);
    case (p)
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0000_0001;
      3: return 32'h0010_0000;
      6: return fds_pkg::INV_RESET;
      default: return (p == 4) ? $urandom : $urandom_range(1, 32'h0004_0000);
    endcase
  endfunction

  // Result sink: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int gap;
    m_tready <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (hold_request) begin
        gap = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      board.check_result(m_tdata[31:0], m_tuser, m_tlast);
    end
  end

  // Watchdog
  initial begin : watchdog
    wait (cycle_count >= LIMIT_CYCLES);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Main sequence
  initial begin : stimulus
    int phase_items;
    int len;
    board = new();
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tlast     <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed grids at the reset reciprocal (1.0)
    pattern = '{SAMPLE_MAX};                       // single-sample grid
    send_pattern();
    pattern = '{SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, // exactly six, saturates both ways
                SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX};
    send_pattern();
    pattern = '{SAMPLE_MAX, 32'hFFFF_FFFF, 32'h0, 32'h1, SAMPLE_MIN};  // five: too short
    send_pattern();
    pattern = '{32'h0001_0000, 32'h0, 32'hFFFF_0000, SAMPLE_MAX,
                32'h0, 32'h0000_0001, SAMPLE_MIN};
    send_pattern();

    // half-LSB ties round away from zero at 0.5
    write_inv(32'h0000_8000);
    pattern = '{32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF};
    send_pattern();

    // random grids over several reciprocal settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_inv(phase_inv(p));
      no_idle = (p == 5);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        len = pick_grid_len();
        send_random_grid(len, $urandom_range(STYLE_FULL, STYLE_MIXED));
        phase_items += len;
      end
    end
    no_idle = 1'b0;

    // long output hold-off while samples keep coming: input must back up
    write_inv($urandom_range(1, 32'h0002_0000));
    hold_request = 1'b1;
    sender_rush = 1'b1;
    send_random_grid(30, STYLE_SMALL);
    sender_rush = 1'b0;

    drain_results();
    $display("Covered %0d samples in %0d grids, %0d results checked",
             board.samples_noted, grids_sent, board.results_checked);
    $display("(%0d too short, %0d saturated), %0d reciprocal writes, stalls on both sides.",
             board.short_count, board.saturated_count, settings_used);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
